// File: rtl/core/ddw_pkg.sv
// Shared types, constants and calendar functions for the date difference block
package ddw_pkg;

	localparam int YEAR_MAX = 9999;

	localparam int DAYNUM_W = 22;
	localparam int MTOT_W   = 17;

	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_100_S = 19;
	localparam logic [22:0] RECIP_7     = 23'd4793491;
	localparam int          RECIP_7_S   = 25;
	localparam logic [15:0] RECIP_3     = 16'd43691;
	localparam int          RECIP_3_S   = 17;

	typedef struct packed {
		logic                ok;
		logic                leap;
		logic [4:0]          day;
		logic [3:0]          month;
		logic [DAYNUM_W-1:0] daynum;
	} date_info_t;

	typedef struct packed {
		logic                err;
		logic [DAYNUM_W-1:0] total_days;
		logic [MTOT_W-1:0]   mtot;
		logic [4:0]          days;
		logic [DAYNUM_W-1:0] n1;
		logic [DAYNUM_W-1:0] n2;
	} diff_t;

	typedef struct packed {
		logic        date_error;
		logic [13:0] age_years;
		logic [3:0]  age_months;
		logic [4:0]  age_days;
		logic [16:0] total_months;
		logic [21:0] total_days;
		logic [18:0] total_weeks;
		logic [2:0]  birth_weekday;
		logic [2:0]  today_weekday;
	} res_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd2:  n = 9'd31;
			4'd3:  n = 9'd59;
			4'd4:  n = 9'd90;
			4'd5:  n = 9'd120;
			4'd6:  n = 9'd151;
			4'd7:  n = 9'd181;
			4'd8:  n = 9'd212;
			4'd9:  n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			4'd12: n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/core/ddw_in_if.sv
// Input channel carrying one birth date and one current date
interface ddw_in_if #(parameter int YEAR_WIDTH = 14) ();
	logic                  valid;
	logic                  ready;
	logic [4:0]            birth_day;
	logic [3:0]            birth_month;
	logic [YEAR_WIDTH-1:0] birth_year;
	logic [4:0]            today_day;
	logic [3:0]            today_month;
	logic [YEAR_WIDTH-1:0] today_year;

	modport source(output valid, birth_day, birth_month, birth_year, today_day, today_month,
		today_year, input ready);
	modport sink(input valid, birth_day, birth_month, birth_year, today_day, today_month,
		today_year, output ready);
endinterface

// File: rtl/core/ddw_out_if.sv
// Output channel carrying the age, totals and weekdays of one date pair
interface ddw_out_if ();
	logic        valid;
	logic        ready;
	logic        date_error;
	logic [13:0] age_years;
	logic [3:0]  age_months;
	logic [4:0]  age_days;
	logic [16:0] total_months;
	logic [21:0] total_days;
	logic [18:0] total_weeks;
	logic [2:0]  birth_weekday;
	logic [2:0]  today_weekday;

	modport source(output valid, date_error, age_years, age_months, age_days, total_months,
		total_days, total_weeks, birth_weekday, today_weekday, input ready);
	modport sink(input valid, date_error, age_years, age_months, age_days, total_months,
		total_days, total_weeks, birth_weekday, today_weekday, output ready);
endinterface

// File: rtl/core/ddw_date.sv
// Three-stage date check and day-number pipeline for one date
module ddw_date #(
	parameter int YEAR_WIDTH = 14
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [4:0]            day,
	input  logic [3:0]            month,
	input  logic [YEAR_WIDTH-1:0] year,
	output ddw_pkg::date_info_t   info_s3,
	output logic [YEAR_WIDTH-1:0] year_s3
);
	import ddw_pkg::*;

	localparam int QW = YEAR_WIDTH - 6;
	localparam int PW = YEAR_WIDTH + 13;

	logic [PW-1:0]         q_prod;
	logic [4:0]            day_s1;
	logic [3:0]            month_s1;
	logic [YEAR_WIDTH-1:0] year_s1;
	logic [QW-1:0]         q_s1;
	logic                  y_ok_s1;
	logic                  m_ok_s1;

	logic [YEAR_WIDTH-1:0] hund;
	logic                  century;
	logic                  leap;
	logic [4:0]            mlen;
	logic [4:0]            day_s2;
	logic [3:0]            month_s2;
	logic [YEAR_WIDTH-1:0] year_s2;
	logic [YEAR_WIDTH-1:0] p_s2;
	logic [QW-1:0]         qp_s2;
	logic                  ok_s2;
	logic                  leap_s2;

	logic [DAYNUM_W-1:0]   daynum;

	assign q_prod = PW'(year) * PW'(RECIP_100);

	always_ff @(posedge clk) begin
		if (en) begin
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			q_s1     <= q_prod[PW-1:RECIP_100_S];
			y_ok_s1  <= (year != '0) && (32'(year) <= YEAR_MAX);
			m_ok_s1  <= (month >= 4'd1) && (month <= 4'd12);
		end
	end

	assign hund    = YEAR_WIDTH'(q_s1) * YEAR_WIDTH'(100);
	assign century = (year_s1 == hund);
	assign leap    = (year_s1[1:0] == 2'd0) && (!century || (q_s1[1:0] == 2'd0));
	assign mlen    = month_len(month_s1, leap);

	always_ff @(posedge clk) begin
		if (en) begin
			day_s2   <= day_s1;
			month_s2 <= month_s1;
			year_s2  <= year_s1;
			p_s2     <= year_s1 - YEAR_WIDTH'(1);
			qp_s2    <= q_s1 - QW'(century);
			leap_s2  <= leap;
			ok_s2    <= y_ok_s1 && m_ok_s1 && (day_s1 != 5'd0) && (day_s1 <= mlen);
		end
	end

	assign daynum = DAYNUM_W'(p_s2) * DAYNUM_W'(365) + DAYNUM_W'(p_s2 >> 2)
		- DAYNUM_W'(qp_s2) + DAYNUM_W'(qp_s2 >> 2) + DAYNUM_W'(days_before(month_s2))
		+ DAYNUM_W'((month_s2 > 4'd2) && leap_s2) + DAYNUM_W'(day_s2) - DAYNUM_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			info_s3.ok     <= ok_s2;
			info_s3.leap   <= leap_s2;
			info_s3.day    <= day_s2;
			info_s3.month  <= month_s2;
			info_s3.daynum <= daynum;
			year_s3        <= year_s2;
		end
	end

endmodule

// File: rtl/core/ddw_diff.sv
// Order check, day difference, month count and day borrow stage
module ddw_diff #(
	parameter int YEAR_WIDTH = 14
) (
	input  logic                  clk,
	input  logic                  en,
	input  ddw_pkg::date_info_t   birth,
	input  ddw_pkg::date_info_t   today,
	input  logic [YEAR_WIDTH-1:0] birth_year,
	input  logic [YEAR_WIDTH-1:0] today_year,
	output ddw_pkg::diff_t        diff_s4
);
	import ddw_pkg::*;

	logic                  borrow;
	logic [4:0]            prev_len;
	logic [4:0]            anchor;
	logic [4:0]            days;
	logic [YEAR_WIDTH-1:0] dy;
	logic [MTOT_W-1:0]     mtot;

	assign borrow   = today.day < birth.day;
	assign prev_len = (today.month == 4'd1) ? 5'd31 : month_len(today.month - 4'd1, today.leap);
	assign anchor   = (birth.day < prev_len) ? birth.day : prev_len;
	assign days     = borrow ? (prev_len - anchor + today.day) : (today.day - birth.day);
	assign dy       = today_year - birth_year;
	assign mtot     = MTOT_W'(dy) * MTOT_W'(12) + MTOT_W'(today.month) - MTOT_W'(birth.month)
		- MTOT_W'(borrow);

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s4.err        <= !birth.ok || !today.ok || (birth.daynum > today.daynum);
			diff_s4.total_days <= today.daynum - birth.daynum;
			diff_s4.mtot       <= mtot;
			diff_s4.days       <= days;
			diff_s4.n1         <= birth.daynum;
			diff_s4.n2         <= today.daynum;
		end
	end

endmodule

// File: rtl/core/ddw_div.sv
// Reciprocal division by 7 and 12 and result assembly, two stages
module ddw_div (
	input  logic           clk,
	input  logic           en,
	input  ddw_pkg::diff_t diff,
	output ddw_pkg::res_t  res_s6
);
	import ddw_pkg::*;

	localparam int P7W = DAYNUM_W + 23;
	localparam int P3W = MTOT_W - 2 + 16;
	localparam int Q7W = P7W - RECIP_7_S;
	localparam int Q3W = P3W - RECIP_3_S;

	logic [DAYNUM_W-1:0] nb;
	logic [DAYNUM_W-1:0] nt;
	logic [P7W-1:0]      wk_prod;
	logic [P7W-1:0]      b_prod;
	logic [P7W-1:0]      t_prod;
	logic [P3W-1:0]      m_prod;

	logic                err_s5;
	logic [DAYNUM_W-1:0] total_days_s5;
	logic [MTOT_W-1:0]   mtot_s5;
	logic [4:0]          days_s5;
	logic [DAYNUM_W-1:0] nb_s5;
	logic [DAYNUM_W-1:0] nt_s5;
	logic [Q7W-1:0]      qwk_s5;
	logic [Q7W-1:0]      qb_s5;
	logic [Q7W-1:0]      qt_s5;
	logic [Q3W-1:0]      qy_s5;

	assign nb      = diff.n1 + DAYNUM_W'(1);
	assign nt      = diff.n2 + DAYNUM_W'(1);
	assign wk_prod = P7W'(diff.total_days) * P7W'(RECIP_7);
	assign b_prod  = P7W'(nb) * P7W'(RECIP_7);
	assign t_prod  = P7W'(nt) * P7W'(RECIP_7);
	assign m_prod  = P3W'(diff.mtot[MTOT_W-1:2]) * P3W'(RECIP_3);

	always_ff @(posedge clk) begin
		if (en) begin
			err_s5        <= diff.err;
			total_days_s5 <= diff.total_days;
			mtot_s5       <= diff.mtot;
			days_s5       <= diff.days;
			nb_s5         <= nb;
			nt_s5         <= nt;
			qwk_s5        <= wk_prod[P7W-1:RECIP_7_S];
			qb_s5         <= b_prod[P7W-1:RECIP_7_S];
			qt_s5         <= t_prod[P7W-1:RECIP_7_S];
			qy_s5         <= m_prod[P3W-1:RECIP_3_S];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (err_s5) begin
				res_s6 <= '{date_error: 1'b1, default: '0};
			end else begin
				res_s6.date_error    <= 1'b0;
				res_s6.age_years     <= 14'(qy_s5);
				res_s6.age_months    <= mtot_s5[3:0] - qy_s5[3:0] * 4'd12;
				res_s6.age_days      <= days_s5;
				res_s6.total_months  <= mtot_s5;
				res_s6.total_days    <= total_days_s5;
				res_s6.total_weeks   <= qwk_s5[18:0];
				res_s6.birth_weekday <= nb_s5[2:0] - qb_s5[2:0] * 3'd7;
				res_s6.today_weekday <= nt_s5[2:0] - qt_s5[2:0] * 3'd7;
			end
		end
	end

endmodule

// File: rtl/core/date_difference_and_weekday.sv
// Top level: six-stage date difference and weekday pipeline
// Each input transfer passes through every stage in order, from the date check to the result assembly, before
// its result appears on the output channel. Throughput: one date pair per cycle while the output is not stalled.
// A stalled output holds every stage in place; nothing is dropped or repeated.
// Reset clears the stage valid bits only; the pipeline is empty after reset.
module date_difference_and_weekday #(
	parameter int YEAR_WIDTH = 14
) (
	input logic       clk,
	input logic       arst_n,
	ddw_in_if.sink    dates,
	ddw_out_if.source result
);
	import ddw_pkg::*;

	logic                  en;
	logic [6:1]            v_q;
	date_info_t            birth_s3;
	date_info_t            today_s3;
	logic [YEAR_WIDTH-1:0] birth_year_s3;
	logic [YEAR_WIDTH-1:0] today_year_s3;
	diff_t                 diff_s4;
	res_t                  res_s6;

	assign en          = !v_q[6] || result.ready;
	assign dates.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:1], dates.valid};
		end
	end

	ddw_date #(.YEAR_WIDTH(YEAR_WIDTH)) u_birth (
		.clk     (clk),
		.en      (en),
		.day     (dates.birth_day),
		.month   (dates.birth_month),
		.year    (dates.birth_year),
		.info_s3 (birth_s3),
		.year_s3 (birth_year_s3)
	);

	ddw_date #(.YEAR_WIDTH(YEAR_WIDTH)) u_today (
		.clk     (clk),
		.en      (en),
		.day     (dates.today_day),
		.month   (dates.today_month),
		.year    (dates.today_year),
		.info_s3 (today_s3),
		.year_s3 (today_year_s3)
	);

	ddw_diff #(.YEAR_WIDTH(YEAR_WIDTH)) u_diff (
		.clk        (clk),
		.en         (en),
		.birth      (birth_s3),
		.today      (today_s3),
		.birth_year (birth_year_s3),
		.today_year (today_year_s3),
		.diff_s4    (diff_s4)
	);

	ddw_div u_div (
		.clk    (clk),
		.en     (en),
		.diff   (diff_s4),
		.res_s6 (res_s6)
	);

	assign result.valid         = v_q[6];
	assign result.date_error    = res_s6.date_error;
	assign result.age_years     = res_s6.age_years;
	assign result.age_months    = res_s6.age_months;
	assign result.age_days      = res_s6.age_days;
	assign result.total_months  = res_s6.total_months;
	assign result.total_days    = res_s6.total_days;
	assign result.total_weeks   = res_s6.total_weeks;
	assign result.birth_weekday = res_s6.birth_weekday;
	assign result.today_weekday = res_s6.today_weekday;

endmodule
